FILE: rtl/core/key_matrix_change_events_macros.svh
// Assertion macros shared by the key matrix change event checker.
`ifndef KEY_MATRIX_CHANGE_EVENTS_MACROS_SVH
`define KEY_MATRIX_CHANGE_EVENTS_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define KMCE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key matrix change events: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define KMCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key matrix change events: assertion failed");

`endif

FILE: rtl/core/kmce_pkg.sv
// Package with shared types, widths and the keymap table of the key matrix change event block.
package kmce_pkg;

  localparam int RowW     = 3;
  localparam int RowBitsW = 18;
  localparam int ColW     = 5;
  localparam int KeyW     = 8;
  localparam int MapRows  = 8;
  localparam int MapCols  = 18;

  typedef enum logic {
    KMCE_IDLE,
    KMCE_SCAN
  } kmce_state_e;

  typedef struct packed {
    logic                go;
    logic [RowW-1:0]     row;
    logic [RowBitsW-1:0] bits;
    logic [RowBitsW-1:0] change;
  } kmce_load_t;

  localparam logic [KeyW-1:0] KEYMAP [MapRows][MapCols] = '{
    '{8'h00, 8'h00, 8'h3E, 8'h46, 8'h27, 8'h43, 8'h00, 8'h00, 8'h00,
      8'h4E, 8'h4D, 8'h26, 8'h25, 8'h24, 8'h21, 8'h20, 8'h1F, 8'h1E},
    '{8'h00, 8'h00, 8'hE0, 8'h00, 8'h2D, 8'h42, 8'h00, 8'h4C, 8'h49,
      8'h4B, 8'h4A, 8'h41, 8'h2E, 8'h23, 8'h22, 8'h3B, 8'h3A, 8'h35},
    '{8'h00, 8'h00, 8'h00, 8'hE6, 8'h38, 8'h45, 8'h00, 8'h51, 8'h4F,
      8'h56, 8'h50, 8'h65, 8'h00, 8'h11, 8'h05, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'hE4, 8'h00, 8'h00, 8'h28, 8'h00, 8'h36, 8'h54,
      8'h55, 8'h00, 8'h37, 8'h53, 8'h10, 8'h19, 8'h06, 8'h1B, 8'h1D},
    '{8'h00, 8'h00, 8'h00, 8'hE2, 8'h34, 8'h44, 8'h00, 8'h2C, 8'h62,
      8'h63, 8'h52, 8'h00, 8'h3F, 8'h0B, 8'h0A, 8'h3D, 8'h00, 8'h29},
    '{8'hE7, 8'h00, 8'h00, 8'h00, 8'h33, 8'h31, 8'hE5, 8'h59, 8'h5A,
      8'h5B, 8'h58, 8'h0F, 8'h0E, 8'h0D, 8'h09, 8'h07, 8'h16, 8'h04},
    '{8'h00, 8'hE3, 8'h00, 8'h00, 8'h2F, 8'h2A, 8'hE1, 8'h5C, 8'h5D,
      8'h5E, 8'h00, 8'h40, 8'h30, 8'h1C, 8'h17, 8'h3C, 8'h39, 8'h2B},
    '{8'h00, 8'h00, 8'h48, 8'h47, 8'h13, 8'h00, 8'h00, 8'h5F, 8'h60,
      8'h61, 8'h57, 8'h12, 8'h0C, 8'h18, 8'h15, 8'h08, 8'h1A, 8'h14}
  };

  // Keys outside the table map to keycode zero.
  function automatic logic [KeyW-1:0] keymap_lookup(logic [ColW-1:0] r, logic [ColW-1:0] c);
    logic [KeyW-1:0] code;
    code = '0;
    if ((r < ColW'(MapRows)) && (c < ColW'(MapCols))) begin
      code = KEYMAP[r[RowW-1:0]][c];
    end
    return code;
  endfunction

endpackage

FILE: rtl/core/key_matrix_change_events.sv
// Top level of the key matrix change event block.
//
//   Channel   Direction   Beat carries
//   row       in          row_index, row_bits, row_ghosted
//   event     out         event_row, event_col, event_keycode, event_pressed, event_last
//
// A row beat that changes nothing, is ghosted or names a row past ROWS leaves the input ready.
// A row beat with changes holds the input while the change shift register walks up to its
// highest changed column (at most 18 columns scanned), moving one bit a cycle when not stalled.
// A stalled event output holds that walk on the column with the next event.
// Reset clears every stored row to no keys pressed; there is no clearing pass.
module key_matrix_change_events #(
  parameter int ROWS = 8,
  parameter int COLS = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          row_valid_i,
  output logic                          row_ready_o,
  input  logic [kmce_pkg::RowW-1:0]     row_index_i,
  input  logic [kmce_pkg::RowBitsW-1:0] row_bits_i,
  input  logic                          row_ghosted_i,
  output logic                          event_valid_o,
  input  logic                          event_ready_i,
  output logic [kmce_pkg::RowW-1:0]     event_row_o,
  output logic [kmce_pkg::ColW-1:0]     event_col_o,
  output logic [kmce_pkg::KeyW-1:0]     event_keycode_o,
  output logic                          event_pressed_o,
  output logic                          event_last_o
);

  localparam int ScanCols = (COLS < kmce_pkg::RowBitsW) ? COLS : kmce_pkg::RowBitsW;
  localparam int RowIdxW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                             busy, accept, row_ok, write_row;
  logic [RowIdxW+kmce_pkg::RowW-1:0] idx_ext;
  logic [RowIdxW-1:0]               idx;
  logic [COLS-1:0]                  stored, wr_data;
  logic [ScanCols-1:0]              bits_scan, change;
  kmce_pkg::kmce_load_t             load;

  assign row_ready_o = !busy;
  assign accept      = row_valid_i && row_ready_o;
  assign row_ok      = (32'(row_index_i) < ROWS);
  assign idx_ext     = (RowIdxW + kmce_pkg::RowW)'(row_index_i);
  assign idx         = idx_ext[RowIdxW-1:0];

  assign bits_scan = row_bits_i[ScanCols-1:0];
  assign change    = bits_scan ^ stored[ScanCols-1:0];
  assign wr_data   = COLS'(bits_scan);
  assign write_row = accept && row_ok && !row_ghosted_i && (change != '0);

  assign load.go     = write_row;
  assign load.row    = row_index_i;
  assign load.bits   = kmce_pkg::RowBitsW'(bits_scan);
  assign load.change = kmce_pkg::RowBitsW'(change);

  kmce_row_store #(
    .ROWS    (ROWS),
    .COLS    (COLS),
    .ROW_IDX (RowIdxW)
  ) u_row_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (idx),
    .wr_en_i   (write_row),
    .wr_data_i (wr_data),
    .rd_data_o (stored)
  );

  kmce_serializer #(
    .SCAN_COLS (ScanCols)
  ) u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .busy_o          (busy),
    .event_valid_o   (event_valid_o),
    .event_ready_i   (event_ready_i),
    .event_row_o     (event_row_o),
    .event_col_o     (event_col_o),
    .event_keycode_o (event_keycode_o),
    .event_pressed_o (event_pressed_o),
    .event_last_o    (event_last_o)
  );

endmodule

FILE: rtl/core/kmce_row_store.sv
// Register file holding the last non-ghosted column bits written for every matrix row.
module kmce_row_store #(
  parameter int ROWS    = 8,
  parameter int COLS    = 18,
  parameter int ROW_IDX = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ROW_IDX-1:0] idx_i,
  input  logic               wr_en_i,
  input  logic [COLS-1:0]    wr_data_i,
  output logic [COLS-1:0]    rd_data_o
);

  logic [COLS-1:0] rows_q [ROWS];
  logic            idx_ok;

  assign idx_ok    = (32'(idx_i) < ROWS);
  assign rd_data_o = idx_ok ? rows_q[idx_i] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) begin
        rows_q[i] <= '0;
      end
    end else if (wr_en_i && idx_ok) begin
      rows_q[idx_i] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/core/kmce_serializer.sv
// Bit-serial walk over the changed columns of one row, with the event output register.
module kmce_serializer #(
  parameter int SCAN_COLS = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kmce_pkg::kmce_load_t          load_i,
  output logic                          busy_o,
  output logic                          event_valid_o,
  input  logic                          event_ready_i,
  output logic [kmce_pkg::RowW-1:0]     event_row_o,
  output logic [kmce_pkg::ColW-1:0]     event_col_o,
  output logic [kmce_pkg::KeyW-1:0]     event_keycode_o,
  output logic                          event_pressed_o,
  output logic                          event_last_o
);

  kmce_pkg::kmce_state_e state_q, state_d;

  logic [SCAN_COLS-1:0]          chg_q, new_q, chg_rest, new_rest;
  logic [kmce_pkg::ColW-1:0]     col_q;
  logic [kmce_pkg::RowW-1:0]     row_q;
  logic                          slot_free, step, emit, done;

  logic                          ev_valid_q, ev_valid_d;
  logic [kmce_pkg::RowW-1:0]     ev_row_q;
  logic [kmce_pkg::ColW-1:0]     ev_col_q;
  logic [kmce_pkg::KeyW-1:0]     ev_key_q;
  logic                          ev_pressed_q, ev_last_q;

  assign chg_rest  = chg_q >> 1;
  assign new_rest  = new_q >> 1;
  assign done      = (chg_rest == '0);
  assign slot_free = !ev_valid_q || event_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      kmce_pkg::KMCE_IDLE: begin
        if (load_i.go) begin
          state_d = kmce_pkg::KMCE_SCAN;
        end
      end
      kmce_pkg::KMCE_SCAN: begin
        if (emit && done) begin
          state_d = kmce_pkg::KMCE_IDLE;
        end
      end
      default: state_d = kmce_pkg::KMCE_IDLE;
    endcase
  end

  always_comb begin
    busy_o = 1'b0;
    step   = 1'b0;
    emit   = 1'b0;
    case (state_q)
      kmce_pkg::KMCE_IDLE: begin
        busy_o = 1'b0;
      end
      kmce_pkg::KMCE_SCAN: begin
        busy_o = 1'b1;
        emit   = chg_q[0] && slot_free;
        step   = !chg_q[0] || slot_free;
      end
      default: busy_o = 1'b0;
    endcase
  end

  always_comb begin
    ev_valid_d = ev_valid_q;
    if (emit) begin
      ev_valid_d = 1'b1;
    end else if (event_ready_i) begin
      ev_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kmce_pkg::KMCE_IDLE;
      ev_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.go) begin
      chg_q <= load_i.change[SCAN_COLS-1:0];
      new_q <= load_i.bits[SCAN_COLS-1:0];
      col_q <= '0;
      row_q <= load_i.row;
    end else if (step) begin
      chg_q <= chg_rest;
      new_q <= new_rest;
      col_q <= col_q + kmce_pkg::ColW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ev_row_q     <= row_q;
      ev_col_q     <= col_q;
      ev_key_q     <= kmce_pkg::keymap_lookup({2'b00, row_q}, col_q);
      ev_pressed_q <= new_q[0];
      ev_last_q    <= done;
    end
  end

  assign event_valid_o   = ev_valid_q;
  assign event_row_o     = ev_row_q;
  assign event_col_o     = ev_col_q;
  assign event_keycode_o = ev_key_q;
  assign event_pressed_o = ev_pressed_q;
  assign event_last_o    = ev_last_q;

endmodule

FILE: rtl/core/kmce_checker.sv
// Port-level checker for the key matrix change event block, bound to its top level.
`include "key_matrix_change_events_macros.svh"

module kmce_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          row_valid_i,
  input logic                          row_ready_o,
  input logic                          row_ghosted_i,
  input logic                          event_valid_o,
  input logic                          event_ready_i,
  input logic [kmce_pkg::RowW-1:0]     event_row_o,
  input logic [kmce_pkg::ColW-1:0]     event_col_o,
  input logic [kmce_pkg::KeyW-1:0]     event_keycode_o,
  input logic                          event_pressed_o,
  input logic                          event_last_o
);

  localparam int BeatW = kmce_pkg::RowW + kmce_pkg::ColW + kmce_pkg::KeyW + 2;

  logic [BeatW-1:0] beat;

  assign beat = {event_row_o, event_col_o, event_keycode_o, event_pressed_o, event_last_o};

  // A stalled event beat keeps its payload.
  `KMCE_ASSERT_NEXT(a_event_hold, event_valid_o && !event_ready_i, event_valid_o && $stable(beat))

  // While a row still owes events, no new row is taken.
  `KMCE_ASSERT_NOW(a_busy_until_last, event_valid_o && event_ready_i && !event_last_o, !row_ready_o)

  // A ghosted row causes no walk, so the block is ready again at once.
  `KMCE_ASSERT_NEXT(a_ghost_no_walk, row_valid_i && row_ready_o && row_ghosted_i, row_ready_o)

  // Events only name real matrix columns.
  `KMCE_ASSERT_NOW(a_col_range, event_valid_o, event_col_o <= 5'd17)

endmodule

bind key_matrix_change_events kmce_checker u_kmce_checker (.*);
